// ===== design/mono_framebuffer_draw_engine_core_macros.svh =====
// Assertion macros shared by the design files.
`ifndef MONO_FRAMEBUFFER_DRAW_ENGINE_CORE_MACROS_SVH
`define MONO_FRAMEBUFFER_DRAW_ENGINE_CORE_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define MFB_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define MFB_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== design/mfb_pkg.sv =====
// ----------------------------------------------------------------------------
// mfb_pkg
// Types, constants and the glyph table of the framebuffer draw engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package mfb_pkg;
  localparam int DispWidth = 128;
  localparam int PageCount = 8;
  localparam int DispHeight = PageCount * 8;
  localparam int MemDepth = DispWidth * PageCount;
  localparam int AddrW = $clog2(MemDepth);
  localparam int ColW = $clog2(DispWidth);

  localparam logic [2:0] KindClear = 3'd0;
  localparam logic [2:0] KindPixel = 3'd1;
  localparam logic [2:0] KindChar  = 3'd2;
  localparam logic [2:0] KindHline = 3'd3;
  localparam logic [2:0] KindVline = 3'd4;
  localparam logic [2:0] KindRect  = 3'd5;
  localparam logic [2:0] KindFill  = 3'd6;
  localparam logic [2:0] KindRead  = 3'd7;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] pos_x;
    logic [7:0] pos_y;
    logic       pixel_on;
    logic [7:0] glyph_code;
    logic [7:0] span_w;
    logic [7:0] span_h;
    logic [2:0] read_page;
  } cmd_t;

  // One pixel operation from the walker to the pixel unit.
  typedef struct packed {
    logic       vld;
    logic [7:0] x;
    logic [7:0] y;
    logic       on;
  } pix_req_t;

  function automatic logic [39:0] glyph_row(input logic [7:0] code);
    logic [39:0] g;
    case (code)
      8'd33: g = 40'h00005F0000; 8'd34: g = 40'h0007000700; 8'd35: g = 40'h147F147F14;
      8'd36: g = 40'h242A7F2A12; 8'd37: g = 40'h2313086462; 8'd38: g = 40'h3649552250;
      8'd39: g = 40'h0005030000; 8'd40: g = 40'h001C224100; 8'd41: g = 40'h0041221C00;
      8'd42: g = 40'h082A1C2A08; 8'd43: g = 40'h08083E0808; 8'd44: g = 40'h0050300000;
      8'd45: g = 40'h0808080808; 8'd46: g = 40'h0060600000; 8'd47: g = 40'h2010080402;
      8'd48: g = 40'h3E5149453E; 8'd49: g = 40'h00427F4000; 8'd50: g = 40'h4261514946;
      8'd51: g = 40'h2141454B31; 8'd52: g = 40'h1814127F10; 8'd53: g = 40'h2745454539;
      8'd54: g = 40'h3C4A494930; 8'd55: g = 40'h0171090503; 8'd56: g = 40'h3649494936;
      8'd57: g = 40'h064949291E; 8'd58: g = 40'h0036360000; 8'd59: g = 40'h0056360000;
      8'd60: g = 40'h0008142241; 8'd61: g = 40'h1414141414; 8'd62: g = 40'h4122140800;
      8'd63: g = 40'h0201510906; 8'd64: g = 40'h324979413E; 8'd65: g = 40'h7E1111117E;
      8'd66: g = 40'h7F49494936; 8'd67: g = 40'h3E41414122; 8'd68: g = 40'h7F4141221C;
      8'd69: g = 40'h7F49494941; 8'd70: g = 40'h7F09090101; 8'd71: g = 40'h3E41415132;
      8'd72: g = 40'h7F0808087F; 8'd73: g = 40'h00417F4100; 8'd74: g = 40'h2040413F01;
      8'd75: g = 40'h7F08142241; 8'd76: g = 40'h7F40404040; 8'd77: g = 40'h7F0204027F;
      8'd78: g = 40'h7F0408107F; 8'd79: g = 40'h3E4141413E; 8'd80: g = 40'h7F09090906;
      8'd81: g = 40'h3E4151215E; 8'd82: g = 40'h7F09192946; 8'd83: g = 40'h4649494931;
      8'd84: g = 40'h01017F0101; 8'd85: g = 40'h3F4040403F; 8'd86: g = 40'h1F2040201F;
      8'd87: g = 40'h7F2018207F; 8'd88: g = 40'h6314081463; 8'd89: g = 40'h0304780403;
      8'd90: g = 40'h6151494543; 8'd91: g = 40'h00007F4141; 8'd92: g = 40'h0204081020;
      8'd93: g = 40'h41417F0000; 8'd94: g = 40'h0402010204; 8'd95: g = 40'h4040404040;
      8'd96: g = 40'h0001020400; 8'd97: g = 40'h2054545478; 8'd98: g = 40'h7F48444438;
      8'd99: g = 40'h3844444420; 8'd100: g = 40'h384444487F; 8'd101: g = 40'h3854545418;
      8'd102: g = 40'h087E090102; 8'd103: g = 40'h081454543C; 8'd104: g = 40'h7F08040478;
      8'd105: g = 40'h00447D4000; 8'd106: g = 40'h2040443D00; 8'd107: g = 40'h007F102844;
      8'd108: g = 40'h00417F4000; 8'd109: g = 40'h7C04180478; 8'd110: g = 40'h7C08040478;
      8'd111: g = 40'h3844444438; 8'd112: g = 40'h7C14141408; 8'd113: g = 40'h081414187C;
      8'd114: g = 40'h7C08040408; 8'd115: g = 40'h4854545420; 8'd116: g = 40'h043F444020;
      8'd117: g = 40'h3C4040207C; 8'd118: g = 40'h1C2040201C; 8'd119: g = 40'h3C4030403C;
      8'd120: g = 40'h4428102844; 8'd121: g = 40'h0C5050503C; 8'd122: g = 40'h4464544C44;
      8'd123: g = 40'h0008364100; 8'd124: g = 40'h00007F0000; 8'd125: g = 40'h0041360800;
      8'd126: g = 40'h08082A1C08;
      default: g = 40'h0;
    endcase
    return g;
  endfunction

  // Font column c of a glyph; columns 0..4 hold the font, 5 and above are blank.
  function automatic logic [7:0] glyph_col(input logic [7:0] code, input logic [2:0] c);
    logic [39:0] g;
    logic [7:0] r;
    g = glyph_row(code);
    case (c)
      3'd0: r = g[39:32];
      3'd1: r = g[31:24];
      3'd2: r = g[23:16];
      3'd3: r = g[15:8];
      3'd4: r = g[7:0];
      default: r = 8'h00;
    endcase
    return r;
  endfunction
endpackage

// ===== design/mfb_stream_if.sv =====
// ----------------------------------------------------------------------------
// mfb_stream_if
// Valid/ready channel carrying one payload of parameter type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
interface mfb_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== design/mfb_ram.sv =====
// ----------------------------------------------------------------------------
// mfb_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module mfb_ram #(
  parameter int Width = 8,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[addr_i] <= wdata_i;
    rdata_o <= mem_q[addr_i];
  end
endmodule

// ===== design/mfb_pixel_unit.sv =====
// ----------------------------------------------------------------------------
// mfb_pixel_unit
// Read-modify-write of one framebuffer bit per request, plus clear and read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module mfb_pixel_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mfb_pkg::pix_req_t req_i,
  input  logic              clr_i,
  input  logic [mfb_pkg::AddrW-1:0] clr_addr_i,
  input  logic              rd_i,
  input  logic [mfb_pkg::AddrW-1:0] rd_addr_i,
  output logic              busy_o,
  output logic [7:0]        rdata_o
);
  import mfb_pkg::*;
  `include "mono_framebuffer_draw_engine_core_macros.svh"

  // Stage 1 reads the byte, stage 2 writes it back with the bit changed.
  logic              st_q, st_d;
  logic [AddrW-1:0]  a_q;
  logic [2:0]        bit_q;
  logic              on_q;
  logic              we;
  logic [AddrW-1:0]  addr;
  logic [7:0]        wdata, ram_q;
  logic              in_range;
  logic [AddrW-1:0]  pa;

  assign in_range = (req_i.x < 8'(DispWidth)) && (req_i.y < 8'(DispHeight));
  assign pa = AddrW'({req_i.y[7:3], req_i.x[ColW-1:0]} & ((1 << AddrW) - 1));

  always_comb begin
    we = 1'b0;
    addr = pa;
    wdata = 8'h00;
    st_d = 1'b0;
    if (st_q) begin
      we = 1'b1;
      addr = a_q;
      wdata = on_q ? (ram_q | (8'h1 << bit_q)) : (ram_q & ~(8'h1 << bit_q));
    end else if (clr_i) begin
      we = 1'b1;
      addr = clr_addr_i;
    end else if (rd_i) begin
      addr = rd_addr_i;
    end else if (req_i.vld && in_range) begin
      st_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) st_q <= 1'b0;
    else st_q <= st_d;
  end

  always_ff @(posedge clk_i) begin
    if (!st_q) begin
      a_q <= pa;
      bit_q <= req_i.y[2:0];
      on_q <= req_i.on;
    end
  end

  mfb_ram #(.Width(8), .Depth(MemDepth)) u_ram (
    .clk_i(clk_i), .we_i(we), .addr_i(addr), .wdata_i(wdata), .rdata_o(ram_q)
  );

  assign busy_o = st_q;
  assign rdata_o = ram_q;

  `MFB_ASSERT_NXT(a_wb_once, clk_i, rst_ni, st_q, !st_q)
  `MFB_ASSERT_NXT(a_wb_after_req, clk_i, rst_ni, !st_q && !clr_i && !rd_i && req_i.vld
    && in_range, st_q)
  `MFB_ASSERT_IMP(a_no_clr_in_wb, clk_i, rst_ni, st_q, !clr_i)
endmodule

// ===== design/mono_framebuffer_draw_engine_core.sv =====
// Monochrome framebuffer draw engine, 128x64 pixels in 8 pages of 128 bytes.
// Commands enter on cmd_in (one beat per command) and read results leave on
// rsp_out. The engine takes one command at a time: ready is low while it
// works. A sequencer walks the pixels of a command and hands each to the
// pixel unit, which reads the RAM byte and then writes it back with the bit
// changed. Clear sweeps all 1024 bytes, one byte per cycle. A read addresses
// the RAM in StRead, captures the byte in StRead2 and presents its result
// beat in StOut, where it waits in an output register until the receiver
// takes it; the next command is accepted meanwhile only after the result
// has left. After reset the engine runs a clearing pass over all 1024 bytes
// during which no command is accepted. Pixels that fall outside the display
// are skipped.
// ----------------------------------------------------------------------------
// mono_framebuffer_draw_engine_core
// Command sequencer and pixel walker of the framebuffer draw engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module mono_framebuffer_draw_engine_core (
  input  logic  clk_i,
  input  logic  rst_ni,
  mfb_stream_if.sink   cmd_in,
  mfb_stream_if.source rsp_out
);
  import mfb_pkg::*;
  `include "mono_framebuffer_draw_engine_core_macros.svh"

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StClear = 3'd1;
  localparam logic [2:0] StWalk  = 3'd2;
  localparam logic [2:0] StRead  = 3'd3;
  localparam logic [2:0] StRead2 = 3'd4;
  localparam logic [2:0] StOut   = 3'd5;

  logic [2:0] st_q, st_d;
  cmd_t       cmd_q, cmd_d;
  logic [AddrW-1:0] cnt_q, cnt_d;
  logic [7:0] i_q, i_d, j_q, j_d;
  logic [1:0] seg_q, seg_d;
  logic [7:0] rb_q, rb_d;
  pix_req_t   req;
  logic       busy;
  logic [7:0] ram_rd;
  logic       rd_ok;
  logic [7:0] gcode;
  logic [7:0] gbits;
  logic [7:0] i_lim, j_lim;
  logic       last_i, last_j;

  assign gcode = (cmd_q.glyph_code >= 8'd32 && cmd_q.glyph_code <= 8'd126)
                 ? cmd_q.glyph_code : 8'd32;
  assign gbits = glyph_col(gcode, i_q[2:0]);
  assign rd_ok = ({2'b00, cmd_q.read_page} < 5'(PageCount)) &&
                 (cmd_q.pos_x < 8'(DispWidth));

  // Walk limits per command; outline segments are hline, hline, vline, vline.
  always_comb begin
    i_lim = 8'd1; j_lim = 8'd1;
    case (cmd_q.kind)
      KindChar:  begin i_lim = 8'd6; j_lim = 8'd8; end
      KindHline: i_lim = cmd_q.span_w;
      KindVline: j_lim = cmd_q.span_h;
      KindRect:  if (seg_q[1]) j_lim = cmd_q.span_h;
                 else i_lim = cmd_q.span_w;
      KindFill:  begin i_lim = cmd_q.span_w; j_lim = cmd_q.span_h; end
      default:   ;
    endcase
  end
  assign last_i = (i_q + 8'd1 >= i_lim);
  assign last_j = (j_q + 8'd1 >= j_lim);

  always_comb begin
    req.vld = (st_q == StWalk) && !busy && (i_lim != 8'd0) && (j_lim != 8'd0);
    req.x = cmd_q.pos_x + i_q;
    req.y = cmd_q.pos_y + j_q;
    req.on = 1'b1;
    if (cmd_q.kind == KindPixel) req.on = cmd_q.pixel_on;
    if (cmd_q.kind == KindChar) req.on = gbits[j_q[2:0]];
    if (cmd_q.kind == KindRect) begin
      if (seg_q == 2'd1) req.y = cmd_q.pos_y + cmd_q.span_h - 8'd1 + j_q;
      if (seg_q == 2'd3) req.x = cmd_q.pos_x + cmd_q.span_w - 8'd1 + i_q;
    end
  end

  always_comb begin
    st_d = st_q; cmd_d = cmd_q; cnt_d = cnt_q;
    i_d = i_q; j_d = j_q; seg_d = seg_q; rb_d = rb_q;
    case (st_q)
      StIdle: if (cmd_in.valid && !busy) begin
        cmd_d = cmd_in.data;
        i_d = 8'd0; j_d = 8'd0; seg_d = 2'd0; cnt_d = '0;
        case (cmd_in.data.kind)
          KindClear: st_d = StClear;
          KindRead:  st_d = StRead;
          default:   st_d = StWalk;
        endcase
      end
      StClear: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == AddrW'(MemDepth - 1)) st_d = StIdle;
      end
      StWalk: if (!busy) begin
        // Lines, outlines and glyphs step the row inside the column; a fill
        // steps the column inside the row.
        if (i_lim == 8'd0 || j_lim == 8'd0 || (last_i && last_j)) begin
          i_d = 8'd0; j_d = 8'd0;
          if (cmd_q.kind == KindRect && seg_q != 2'd3) seg_d = seg_q + 2'd1;
          else st_d = StIdle;
        end else if (cmd_q.kind == KindFill ? last_i : !last_j) begin
          if (cmd_q.kind == KindFill) begin i_d = 8'd0; j_d = j_q + 8'd1; end
          else j_d = j_q + 8'd1;
        end else if (cmd_q.kind == KindFill) begin
          i_d = i_q + 8'd1;
        end else begin
          j_d = 8'd0; i_d = i_q + 8'd1;
        end
      end
      StRead:  st_d = StRead2;
      StRead2: begin rb_d = rd_ok ? ram_rd : 8'h00; st_d = StOut; end
      StOut:   if (rsp_out.ready) st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StClear; cnt_q <= '0; i_q <= 8'd0; j_q <= 8'd0; seg_q <= 2'd0;
    end else begin
      st_q <= st_d; cnt_q <= cnt_d; i_q <= i_d; j_q <= j_d; seg_q <= seg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    rb_q <= rb_d;
  end

  mfb_pixel_unit u_pix (
    .clk_i(clk_i), .rst_ni(rst_ni), .req_i(req),
    .clr_i(st_q == StClear), .clr_addr_i(cnt_q),
    .rd_i(st_q == StRead),
    .rd_addr_i(AddrW'({cmd_q.read_page, cmd_q.pos_x[ColW-1:0]})),
    .busy_o(busy), .rdata_o(ram_rd)
  );

  assign cmd_in.ready = (st_q == StIdle) && !busy;
  assign rsp_out.valid = (st_q == StOut);
  assign rsp_out.data = rb_q;

  `MFB_ASSERT_NXT(a_out_holds, clk_i, rst_ni, rsp_out.valid && !rsp_out.ready,
    rsp_out.valid && $stable(rsp_out.data))
  `MFB_ASSERT_IMP(a_no_accept_busy, clk_i, rst_ni, cmd_in.ready, !busy)
  `MFB_ASSERT_NXT(a_read_path, clk_i, rst_ni, st_q == StRead, st_q == StRead2)
endmodule

// ===== dv/tb_mono_framebuffer_draw_engine_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mono_framebuffer_draw_engine_core
// Drives drawing and read-back commands into the framebuffer draw engine and
// checks every read-back byte against a shadow framebuffer kept in the bench.
// ----------------------------------------------------------------------------
module tb_mono_framebuffer_draw_engine_core;
  import mfb_pkg::*;

  localparam int WatchdogLimit = 400000;

  logic clk_i;
  logic rst_ni;

  mfb_stream_if #(.payload_t(cmd_t))       cmd_if ();
  mfb_stream_if #(.payload_t(logic [7:0])) rsp_if ();

  mono_framebuffer_draw_engine_core dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_in  (cmd_if.sink),
    .rsp_out (rsp_if.source)
  );

  // Font columns for codes 32..126, column 0 in the top byte.
  localparam logic [39:0] FontCols [95] = '{
    40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14, 40'h242A7F2A12,
    40'h2313086462, 40'h3649552250, 40'h0005030000, 40'h001C224100, 40'h0041221C00,
    40'h082A1C2A08, 40'h08083E0808, 40'h0050300000, 40'h0808080808, 40'h0060600000,
    40'h2010080402, 40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
    40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503, 40'h3649494936,
    40'h064949291E, 40'h0036360000, 40'h0056360000, 40'h0008142241, 40'h1414141414,
    40'h4122140800, 40'h0201510906, 40'h324979413E, 40'h7E1111117E, 40'h7F49494936,
    40'h3E41414122, 40'h7F4141221C, 40'h7F49494941, 40'h7F09090101, 40'h3E41415132,
    40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241, 40'h7F40404040,
    40'h7F0204027F, 40'h7F0408107F, 40'h3E4141413E, 40'h7F09090906, 40'h3E4151215E,
    40'h7F09192946, 40'h4649494931, 40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F,
    40'h7F2018207F, 40'h6314081463, 40'h0304780403, 40'h6151494543, 40'h00007F4141,
    40'h0204081020, 40'h41417F0000, 40'h0402010204, 40'h4040404040, 40'h0001020400,
    40'h2054545478, 40'h7F48444438, 40'h3844444420, 40'h384444487F, 40'h3854545418,
    40'h087E090102, 40'h081454543C, 40'h7F08040478, 40'h00447D4000, 40'h2040443D00,
    40'h007F102844, 40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
    40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420, 40'h043F444020,
    40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C, 40'h4428102844, 40'h0C5050503C,
    40'h4464544C44, 40'h0008364100, 40'h00007F0000, 40'h0041360800, 40'h08082A1C08
  };

  logic [7:0] shadow_fb [MemDepth];
  logic [7:0] read_bytes_due [$];
  bit gaps_on;
  int rsp_hold_cycles;
  int quiet_cycles;
  int error_count;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Shadow framebuffer: every coordinate is already taken mod 256.
  function automatic void shadow_put(input logic [7:0] x, input logic [7:0] y,
                                     input logic on);
    int idx;
    if (x >= DispWidth || y >= DispHeight) return;
    idx = int'(y[7:3]) * DispWidth + int'(x);
    shadow_fb[idx][y[2:0]] = on;
  endfunction

  function automatic void shadow_hline(input logic [7:0] x, input logic [7:0] y,
                                       input logic [7:0] w);
    for (int i = 0; i < int'(w); i++) shadow_put(x + 8'(i), y, 1'b1);
  endfunction

  function automatic void shadow_vline(input logic [7:0] x, input logic [7:0] y,
                                       input logic [7:0] h);
    for (int i = 0; i < int'(h); i++) shadow_put(x, y + 8'(i), 1'b1);
  endfunction

  function automatic void shadow_glyph(input logic [7:0] x, input logic [7:0] y,
                                       input logic [7:0] code);
    logic [7:0] bits;
    int idx;
    idx = (code < 32 || code > 126) ? 0 : int'(code) - 32;
    for (int c = 0; c < 6; c++) begin
      bits = (c < 5) ? FontCols[idx][39 - 8 * c -: 8] : 8'h00;
      for (int r = 0; r < 8; r++) shadow_put(x + 8'(c), y + 8'(r), bits[r]);
    end
  endfunction

  // Applies one accepted command to the shadow and queues any read-back.
  function automatic void apply_cmd(input cmd_t c);
    case (c.kind)
      KindClear: for (int i = 0; i < MemDepth; i++) shadow_fb[i] = 8'h00;
      KindPixel: shadow_put(c.pos_x, c.pos_y, c.pixel_on);
      KindChar:  shadow_glyph(c.pos_x, c.pos_y, c.glyph_code);
      KindHline: shadow_hline(c.pos_x, c.pos_y, c.span_w);
      KindVline: shadow_vline(c.pos_x, c.pos_y, c.span_h);
      KindRect: begin
        shadow_hline(c.pos_x, c.pos_y, c.span_w);
        shadow_hline(c.pos_x, c.pos_y + c.span_h - 8'd1, c.span_w);
        shadow_vline(c.pos_x, c.pos_y, c.span_h);
        shadow_vline(c.pos_x + c.span_w - 8'd1, c.pos_y, c.span_h);
      end
      KindFill: begin
        for (int j = 0; j < int'(c.span_h); j++)
          for (int i = 0; i < int'(c.span_w); i++)
            shadow_put(c.pos_x + 8'(i), c.pos_y + 8'(j), 1'b1);
      end
      default: begin
        if (c.read_page < PageCount && c.pos_x < DispWidth)
          read_bytes_due.push_back(shadow_fb[int'(c.read_page) * DispWidth + int'(c.pos_x)]);
        else
          read_bytes_due.push_back(8'h00);
      end
    endcase
  endfunction

  function automatic cmd_t make_cmd(input logic [2:0] kind, input logic [7:0] x,
                                    input logic [7:0] y, input logic [7:0] w,
                                    input logic [7:0] h);
    cmd_t c;
    c.kind = kind;
    c.pos_x = x;
    c.pos_y = y;
    c.span_w = w;
    c.span_h = h;
    c.pixel_on = 1'b1;
    c.glyph_code = 8'd65;
    c.read_page = y[5:3];
    return c;
  endfunction

  function automatic cmd_t read_cmd(input logic [2:0] page, input logic [7:0] x);
    cmd_t c;
    c = make_cmd(KindRead, x, 8'($urandom), 8'($urandom), 8'($urandom));
    c.pixel_on = 1'($urandom);
    c.glyph_code = 8'($urandom);
    c.read_page = page;
    return c;
  endfunction

  // Drives one command and returns once it has been accepted. Valid stays
  // high afterwards so back-to-back beats need no extra edge.
  task automatic send_cmd(input cmd_t c);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      cmd_if.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    cmd_if.valid <= 1'b1;
    cmd_if.data <= c;
    do @(posedge clk_i); while (!cmd_if.ready);
    apply_cmd(c);
  endtask

  task automatic read_region(input logic [2:0] page, input logic [7:0] x0, input int n);
    for (int i = 0; i < n; i++) send_cmd(read_cmd(page, x0 + 8'(i)));
  endtask

  task automatic test_pixels();
    cmd_t c;
    logic [7:0] xs [4] = '{8'd0, 8'd127, 8'd128, 8'd255};
    logic [7:0] ys [4] = '{8'd0, 8'd63, 8'd64, 8'd255};
    for (int i = 0; i < 4; i++) begin
      c = make_cmd(KindPixel, xs[i], ys[3 - i], 8'd0, 8'd0);
      send_cmd(c);
      c = make_cmd(KindPixel, xs[i], ys[i], 8'd0, 8'd0);
      send_cmd(c);
    end
    c = make_cmd(KindPixel, 8'd0, 8'd0, 8'd0, 8'd0);
    c.pixel_on = 1'b0;
    send_cmd(c);
    send_cmd(read_cmd(3'd0, 8'd0));
    send_cmd(read_cmd(3'd7, 8'd127));
    send_cmd(read_cmd(3'd7, 8'd255));
  endtask

  task automatic test_glyphs();
    cmd_t c;
    logic [7:0] codes [7] = '{8'd0, 8'd31, 8'd32, 8'd65, 8'd126, 8'd127, 8'd255};
    send_cmd(make_cmd(KindFill, 8'd0, 8'd0, 8'd128, 8'd8));
    for (int i = 0; i < 7; i++) begin
      c = make_cmd(KindChar, 8'(i * 6), 8'd0, 8'd0, 8'd0);
      c.glyph_code = codes[i];
      send_cmd(c);
    end
    // A cell that straddles two pages and one that wraps past column 255.
    c = make_cmd(KindChar, 8'd60, 8'd12, 8'd0, 8'd0);
    c.glyph_code = 8'd87;
    send_cmd(c);
    c = make_cmd(KindChar, 8'd253, 8'd20, 8'd0, 8'd0);
    c.glyph_code = 8'd35;
    send_cmd(c);
    read_region(3'd0, 8'd0, 44);
    read_region(3'd1, 8'd60, 6);
    read_region(3'd2, 8'd0, 4);
  endtask

  task automatic test_lines();
    send_cmd(make_cmd(KindClear, 8'd0, 8'd0, 8'd0, 8'd0));
    send_cmd(make_cmd(KindHline, 8'd10, 8'd5, 8'd0, 8'd9));
    send_cmd(make_cmd(KindHline, 8'd200, 8'd6, 8'd255, 8'd0));
    send_cmd(make_cmd(KindVline, 8'd3, 8'd0, 8'd9, 8'd0));
    send_cmd(make_cmd(KindVline, 8'd4, 8'd250, 8'd0, 8'd255));
    read_region(3'd0, 8'd0, 12);
    read_region(3'd7, 8'd4, 1);
  endtask

  task automatic test_rects();
    send_cmd(make_cmd(KindClear, 8'd0, 8'd0, 8'd0, 8'd0));
    send_cmd(make_cmd(KindRect, 8'd20, 8'd20, 8'd0, 8'd0));
    send_cmd(make_cmd(KindRect, 8'd30, 8'd10, 8'd255, 8'd255));
    send_cmd(make_cmd(KindRect, 8'd40, 8'd30, 8'd5, 8'd7));
    send_cmd(make_cmd(KindFill, 8'd60, 8'd40, 8'd0, 8'd20));
    send_cmd(make_cmd(KindFill, 8'd60, 8'd40, 8'd20, 8'd0));
    send_cmd(make_cmd(KindFill, 8'd0, 8'd0, 8'd255, 8'd255));
    send_cmd(make_cmd(KindRect, 8'd10, 8'd10, 8'd40, 8'd30));
    read_region(3'd2, 8'd18, 4);
    read_region(3'd4, 8'd38, 10);
    read_region(3'd7, 8'd120, 8);
  endtask

  // Long receiver stall while draw and read commands keep arriving.
  task automatic test_backpressure();
    rsp_hold_cycles = 400;
    for (int i = 0; i < 8; i++) begin
      send_cmd(read_cmd(3'($urandom), 8'($urandom_range(0, 127))));
      send_cmd(make_cmd(KindPixel, 8'($urandom_range(0, 127)), 8'($urandom_range(0, 63)),
                        8'd0, 8'd0));
    end
  endtask

  function automatic cmd_t rand_cmd();
    cmd_t c;
    int pick;
    c.kind = KindRead;
    c.pos_x = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 135));
    c.pos_y = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 70));
    c.pixel_on = 1'($urandom);
    c.glyph_code = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(32, 126));
    c.span_w = 8'($urandom_range(0, 24));
    c.span_h = 8'($urandom_range(0, 24));
    c.read_page = 3'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 2) c.kind = KindClear;
    else if (pick < 17) c.kind = KindPixel;
    else if (pick < 27) c.kind = KindChar;
    else if (pick < 35) c.kind = KindHline;
    else if (pick < 43) c.kind = KindVline;
    else if (pick < 50) c.kind = KindRect;
    else if (pick < 58) c.kind = KindFill;
    if (c.kind inside {KindHline, KindVline, KindRect} && $urandom_range(0, 5) == 0) begin
      c.span_w = 8'($urandom);
      c.span_h = 8'($urandom);
    end
    if (c.kind == KindFill && $urandom_range(0, 40) == 0) begin
      c.span_w = 8'($urandom_range(128, 255));
      c.span_h = 8'($urandom_range(0, 15));
    end
    return c;
  endfunction

  task automatic test_random(input int n);
    for (int i = 0; i < n; i++) send_cmd(rand_cmd());
  endtask

  // Result side: random stalls, the long hold, and the byte check.
  initial begin
    rsp_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (rsp_if.valid && rsp_if.ready) begin
        if (read_bytes_due.size() == 0) begin
          $error("read_byte beat with nothing expected: actual %02h", rsp_if.data);
          error_count++;
        end else begin
          logic [7:0] due;
          due = read_bytes_due.pop_front();
          if (rsp_if.data !== due) begin
            $error("read_byte mismatch: expected %02h actual %02h", due, rsp_if.data);
            error_count++;
          end
        end
      end
      if (rsp_hold_cycles > 0) begin
        rsp_hold_cycles--;
        rsp_if.ready <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 7) == 0) begin
        rsp_hold_cycles = $urandom_range(1, 5);
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles without any accepted beat.
  always @(posedge clk_i) begin
    if ((cmd_if.valid && cmd_if.ready) || (rsp_if.valid && rsp_if.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("tb_mono_framebuffer_draw_engine_core: FAIL");
      $finish;
    end
  end

  initial begin
    cmd_if.valid = 1'b0;
    cmd_if.data = '0;
    rst_ni = 1'b0;
    gaps_on = 1'b1;
    rsp_hold_cycles = 0;
    quiet_cycles = 0;
    error_count = 0;
    for (int i = 0; i < MemDepth; i++) shadow_fb[i] = 8'h00;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_pixels();
    test_glyphs();
    test_lines();
    test_rects();
    test_backpressure();
    test_random(1150);
    gaps_on = 1'b0;
    test_random(200);
    cmd_if.valid <= 1'b0;
    while (read_bytes_due.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (error_count == 0) begin
      $display("tb_mono_framebuffer_draw_engine_core: PASS");
    end else begin
      $display("tb_mono_framebuffer_draw_engine_core: FAIL");
    end
    $finish;
  end
endmodule

// ===== mono_framebuffer_draw_engine_core.f =====
+incdir+design
design/mfb_pkg.sv
design/mfb_stream_if.sv
design/mfb_ram.sv
design/mfb_pixel_unit.sv
design/mono_framebuffer_draw_engine_core.sv
dv/tb_mono_framebuffer_draw_engine_core.sv
